[rtl/vcls_pkg.sv]
// ----------------------------------------------------------------------------
// vcls_pkg
// Shared types, constants and arithmetic helpers for the velocity command
// limiter and smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package vcls_pkg;

   localparam int unsigned DATA_W  = 16;
   localparam int unsigned CFG_W   = 15;
   localparam int unsigned FRAC_W  = 12;
   localparam int unsigned ADDR_W  = 4;
   localparam int unsigned PDATA_W = 32;

   localparam logic [CFG_W-1:0] LIMIT_MAX = 15'h7FFF;

   localparam logic [CFG_W-1:0] SPEED_LIMIT_RST   = 15'd6144;
   localparam logic [CFG_W-1:0] TURN_LIMIT_RST    = 15'd6144;
   localparam logic [CFG_W-1:0] TURN_DEADBAND_RST = 15'd82;
   localparam logic [CFG_W-1:0] SPEED_STEP_RST    = 15'd102;

   typedef enum logic [1:0] {
      CSR_SPEED_LIMIT   = 2'd0,
      CSR_TURN_LIMIT    = 2'd1,
      CSR_TURN_DEADBAND = 2'd2,
      CSR_SPEED_STEP    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] speed_limit;
      logic [CFG_W-1:0] turn_limit;
      logic [CFG_W-1:0] turn_deadband;
      logic [CFG_W-1:0] speed_step;
   } cfg_type;

   // magnitude of a signed 16-bit value, 17 bits so -32768 is exact
   function automatic logic [DATA_W:0] abs17(input logic signed [DATA_W-1:0] v);
      logic signed [DATA_W:0] w;
      w = {v[DATA_W-1], v};
      return v[DATA_W-1] ? (DATA_W+1)'(-w) : (DATA_W+1)'(w);
   endfunction

   // clamp magnitude to lim, sign kept
   function automatic logic signed [DATA_W-1:0] clamp_mag(
      input logic signed [DATA_W-1:0] v,
      input logic        [CFG_W-1:0]  lim
   );
      logic [DATA_W:0]          mag;
      logic signed [DATA_W-1:0] pos;
      mag = abs17(v);
      pos = $signed({1'b0, lim});
      if (mag > {2'b00, lim}) begin
         return v[DATA_W-1] ? DATA_W'(-pos) : pos;
      end
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat16(input logic signed [DATA_W+1:0] v);
      if (v > 18'sd32767) begin
         return 16'sh7FFF;
      end
      if (v < -18'sd32768) begin
         return 16'sh8000;
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/vcls_req_if.sv]
// ----------------------------------------------------------------------------
// vcls_req_if
// Request channel: one velocity command per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface vcls_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [vcls_pkg::DATA_W-1:0]    speed_request;
   logic signed [vcls_pkg::DATA_W-1:0]    speed_scale;
   logic signed [vcls_pkg::DATA_W-1:0]    turn_request;

   modport source (output valid, output speed_request, output speed_scale,
                   output turn_request, input ready);
   modport sink   (input valid, input speed_request, input speed_scale,
                   input turn_request, output ready);
endinterface

`default_nettype wire

[rtl/vcls_rsp_if.sv]
// ----------------------------------------------------------------------------
// vcls_rsp_if
// Response channel: limited and smoothed command.
// ----------------------------------------------------------------------------
`default_nettype none

interface vcls_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [vcls_pkg::DATA_W-1:0]    speed_out;
   logic signed [vcls_pkg::DATA_W-1:0]    turn_out;

   modport source (output valid, output speed_out, output turn_out, input ready);
   modport sink   (input valid, input speed_out, input turn_out, output ready);
endinterface

`default_nettype wire

[rtl/vcls_csr.sv]
// ----------------------------------------------------------------------------
// vcls_csr
// APB register file holding the limits, deadband and ramp step.
// ----------------------------------------------------------------------------
`default_nettype none

module vcls_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [vcls_pkg::ADDR_W-1:0]       paddr,
   input  wire logic [vcls_pkg::PDATA_W-1:0]      pwdata,
   output logic      [vcls_pkg::PDATA_W-1:0]      prdata,
   output logic                                   pready,
   output vcls_pkg::cfg_type                      cfg
);

   vcls_pkg::cfg_type       cfg_ff;
   vcls_pkg::cfg_type       cfg_in;
   vcls_pkg::csr_index_type sel;
   logic                    wr;
   logic [vcls_pkg::CFG_W-1:0] wval;

   assign sel    = vcls_pkg::csr_index_type'(paddr[3:2]);
   assign wr     = psel && penable && pwrite;
   assign wval   = pwdata[vcls_pkg::CFG_W-1:0];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (sel)
            vcls_pkg::CSR_SPEED_LIMIT:   cfg_in.speed_limit   = wval;
            vcls_pkg::CSR_TURN_LIMIT:    cfg_in.turn_limit    = wval;
            vcls_pkg::CSR_TURN_DEADBAND: cfg_in.turn_deadband = wval;
            vcls_pkg::CSR_SPEED_STEP:    cfg_in.speed_step    = wval;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         vcls_pkg::CSR_SPEED_LIMIT:   prdata = 32'(cfg_ff.speed_limit);
         vcls_pkg::CSR_TURN_LIMIT:    prdata = 32'(cfg_ff.turn_limit);
         vcls_pkg::CSR_TURN_DEADBAND: prdata = 32'(cfg_ff.turn_deadband);
         vcls_pkg::CSR_SPEED_STEP:    prdata = 32'(cfg_ff.speed_step);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_limit   <= vcls_pkg::SPEED_LIMIT_RST;
         cfg_ff.turn_limit    <= vcls_pkg::TURN_LIMIT_RST;
         cfg_ff.turn_deadband <= vcls_pkg::TURN_DEADBAND_RST;
         cfg_ff.speed_step    <= vcls_pkg::SPEED_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/vcls_limit.sv]
// ----------------------------------------------------------------------------
// vcls_limit
// First stage logic: scaled speed limit and turn clamp with deadband.
// ----------------------------------------------------------------------------
`default_nettype none

module vcls_limit (
   input  wire vcls_pkg::cfg_type                cfg,
   input  wire logic signed [vcls_pkg::DATA_W-1:0] speed_scale,
   input  wire logic signed [vcls_pkg::DATA_W-1:0] turn_request,
   output logic        [vcls_pkg::CFG_W-1:0]     speed_lim,
   output logic signed [vcls_pkg::DATA_W-1:0]    turn_out
);

   logic [vcls_pkg::DATA_W:0]                 scale_mag;
   logic [31:0]                               prod;
   logic [31-vcls_pkg::FRAC_W:0]              prod_q;
   logic signed [vcls_pkg::DATA_W-1:0]        turn_clamped;
   logic [vcls_pkg::DATA_W:0]                 turn_mag;

   assign scale_mag = vcls_pkg::abs17(speed_scale);
   assign prod      = 32'(scale_mag) * 32'(cfg.speed_limit);
   assign prod_q    = prod[31:vcls_pkg::FRAC_W];

   always_comb begin
      if (speed_scale == '0) begin
         speed_lim = cfg.speed_limit;
      end else if (|prod_q[31-vcls_pkg::FRAC_W:vcls_pkg::CFG_W]) begin
         speed_lim = vcls_pkg::LIMIT_MAX;
      end else begin
         speed_lim = prod_q[vcls_pkg::CFG_W-1:0];
      end
   end

   assign turn_clamped = vcls_pkg::clamp_mag(turn_request, cfg.turn_limit);
   assign turn_mag     = vcls_pkg::abs17(turn_clamped);
   assign turn_out     = (turn_mag < {2'b00, cfg.turn_deadband}) ? '0 : turn_clamped;

endmodule

`default_nettype wire

[rtl/vcls_smooth.sv]
// ----------------------------------------------------------------------------
// vcls_smooth
// Second stage logic: speed clamp, zero on sign reversal and slew smoother
// against the last output.
`default_nettype none

module vcls_smooth (
   input  wire logic signed [vcls_pkg::DATA_W-1:0] speed_request,
   input  wire logic        [vcls_pkg::CFG_W-1:0]  speed_lim,
   input  wire logic        [vcls_pkg::CFG_W-1:0]  speed_step,
   input  wire logic signed [vcls_pkg::DATA_W-1:0] last,
   output logic signed      [vcls_pkg::DATA_W-1:0] speed_out
);

   logic signed [vcls_pkg::DATA_W-1:0] cmd;
   logic                               cmd_le0;
   logic                               cmd_ge0;
   logic                               last_gt0;
   logic                               last_lt0;
   logic signed [vcls_pkg::DATA_W+1:0] rise;
   logic signed [vcls_pkg::DATA_W+1:0] twice;
   logic signed [vcls_pkg::DATA_W+1:0] last_x;
   logic signed [vcls_pkg::DATA_W+1:0] step_x;

   assign cmd      = vcls_pkg::clamp_mag(speed_request, speed_lim);
   assign cmd_le0  = cmd[vcls_pkg::DATA_W-1] || (cmd == '0);
   assign cmd_ge0  = !cmd[vcls_pkg::DATA_W-1];
   assign last_gt0 = !last[vcls_pkg::DATA_W-1] && (last != '0);
   assign last_lt0 = last[vcls_pkg::DATA_W-1];

   assign rise   = $signed({1'b0, vcls_pkg::abs17(cmd)}) - $signed({1'b0, vcls_pkg::abs17(last)});
   assign twice  = $signed({2'b00, speed_step, 1'b0});
   assign last_x = {{2{last[vcls_pkg::DATA_W-1]}}, last};
   assign step_x = $signed({3'b000, speed_step});

   always_comb begin
      if ((cmd_le0 && last_gt0) || (cmd_ge0 && last_lt0)) begin
         speed_out = '0;
      end else if (rise < twice) begin
         speed_out = cmd;
      end else if (cmd > last) begin
         speed_out = vcls_pkg::sat16(last_x + step_x);
      end else if (cmd < last) begin
         speed_out = vcls_pkg::sat16(last_x - step_x);
      end else begin
         speed_out = cmd;
      end
   end

endmodule

`default_nettype wire

[rtl/velocity_command_limiter_smoother_unit.sv]
// ----------------------------------------------------------------------------
// velocity_command_limiter_smoother_unit
// Limits and smooths a stream of velocity commands.
// ----------------------------------------------------------------------------
// Requests arrive on req_bus (valid/ready): speed, scale and turn, Q4.12.
// Each request yields exactly one response on rsp_bus: clamped and smoothed
// speed plus clamped, deadbanded turn rate.
// Path: an accepted request lands in the input register; limiter and
// smoother work on it in one pass and the response register loads from it
// once the response register is empty or its response is being taken.
// Throughput: one request per cycle unless rsp_bus stalls; the only feedback
// is the last speed output, updated when the response register loads.
// req_bus.ready is high while the input register is empty or can move on.
// When rsp_bus stalls the response holds, one more request is taken into
// the input register, then req_bus.ready drops until the response is taken.
// Registers (APB, byte address 4*i): speed_limit, turn_limit, turn_deadband,
// speed_step; write them only while the block is empty.
// Reset (synchronous): pipeline emptied, last speed cleared to zero,
// registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_command_limiter_smoother_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   vcls_req_if.sink                               req_bus,
   vcls_rsp_if.source                             rsp_bus,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [vcls_pkg::ADDR_W-1:0]       paddr,
   input  wire logic [vcls_pkg::PDATA_W-1:0]      pwdata,
   output logic      [vcls_pkg::PDATA_W-1:0]      prdata,
   output logic                                   pready
);

   vcls_pkg::cfg_type cfg;

   logic s1_v_ff, s1_v_in;
   logic out_v_ff, out_v_in;

   logic signed [vcls_pkg::DATA_W-1:0] s1_speed_ff, s1_scale_ff, s1_turn_ff;
   logic signed [vcls_pkg::DATA_W-1:0] out_speed_ff, out_turn_ff;
   logic signed [vcls_pkg::DATA_W-1:0] prev_speed_ff;

   logic        [vcls_pkg::CFG_W-1:0]  lim_in;
   logic signed [vcls_pkg::DATA_W-1:0] turn_in;
   logic signed [vcls_pkg::DATA_W-1:0] speed_in;

   logic out_free, s1_free;
   logic req_take, s1_go;

   vcls_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vcls_limit u_limit (
      .cfg          (cfg),
      .speed_scale  (s1_scale_ff),
      .turn_request (s1_turn_ff),
      .speed_lim    (lim_in),
      .turn_out     (turn_in)
   );

   vcls_smooth u_smooth (
      .speed_request (s1_speed_ff),
      .speed_lim     (lim_in),
      .speed_step    (cfg.speed_step),
      .last          (prev_speed_ff),
      .speed_out     (speed_in)
   );

   assign out_free = !out_v_ff || rsp_bus.ready;
   assign s1_free  = !s1_v_ff || out_free;
   assign req_take = req_bus.valid && s1_free;
   assign s1_go    = s1_v_ff && out_free;

   assign s1_v_in  = s1_free  ? req_bus.valid : s1_v_ff;
   assign out_v_in = out_free ? s1_v_ff       : out_v_ff;

   assign req_bus.ready     = s1_free;
   assign rsp_bus.valid     = out_v_ff;
   assign rsp_bus.speed_out = out_speed_ff;
   assign rsp_bus.turn_out  = out_turn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff       <= 1'b0;
         out_v_ff      <= 1'b0;
         prev_speed_ff <= '0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
         if (s1_go) begin
            prev_speed_ff <= speed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_speed_ff <= req_bus.speed_request;
         s1_scale_ff <= req_bus.speed_scale;
         s1_turn_ff  <= req_bus.turn_request;
      end
      if (s1_go) begin
         out_speed_ff <= speed_in;
         out_turn_ff  <= turn_in;
      end
   end

`ifndef SYNTH
   a_prev_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_go |=> $stable(prev_speed_ff))
      else $error("last speed changed without a response load");

   a_prev_match: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> (rsp_bus.valid && rsp_bus.speed_out == prev_speed_ff))
      else $error("response speed differs from smoother state");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_bus.valid && !s1_v_ff && prev_speed_ff == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
